// ----- hw/rtl/pmsl_pkg.sv -----
// Shared types, constants and helpers for the PID motor speed loop.
// Used by the register file, the digit-serial multiplier, the duty divider
// and the top level. Depends on nothing.
package pmsl_pkg;

	// Default design parameters
	localparam int PWM_TOP_DEF     = 999;
	localparam int SPEED_LIMIT_DEF = 130;

	// Configuration port
	localparam int CFG_N  = 8;
	localparam int CFG_AW = 5;
	localparam int CFG_IW = 3;

	localparam logic [CFG_IW-1:0] REG_PROP_GAIN      = 3'd0;
	localparam logic [CFG_IW-1:0] REG_INTEG_GAIN     = 3'd1;
	localparam logic [CFG_IW-1:0] REG_DERIV_GAIN     = 3'd2;
	localparam logic [CFG_IW-1:0] REG_LOOP_PERIOD    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_INVERSE_PERIOD = 3'd4;
	localparam logic [CFG_IW-1:0] REG_RPM_PER_COUNT  = 3'd5;
	localparam logic [CFG_IW-1:0] REG_INTEGRAL_LIMIT = 3'd6;
	localparam logic [CFG_IW-1:0] REG_ERROR_THRESH   = 3'd7;

	localparam logic [31:0] RST_PROP_GAIN      = 32'd20132659;
	localparam logic [31:0] RST_INTEG_GAIN     = 32'd8388608;
	localparam logic [31:0] RST_DERIV_GAIN     = 32'd167772;
	localparam logic [31:0] RST_LOOP_PERIOD    = 32'd1677722;
	localparam logic [31:0] RST_INVERSE_PERIOD = 32'd655360;
	localparam logic [31:0] RST_RPM_PER_COUNT  = 32'd5084005;
	localparam logic [30:0] RST_INTEGRAL_LIMIT = 31'd13107200;
	localparam logic [30:0] RST_ERROR_THRESH   = 31'd655360;

	// Input kinds (tuser)
	localparam logic KIND_TICK     = 1'b0;
	localparam logic KIND_SETPOINT = 1'b1;

	// Stream widths
	localparam int IN_W  = 48;
	localparam int OUT_W = 80;

	// Digit-serial multiplier geometry
	localparam int MUL_A_W   = 33;
	localparam int MUL_G_W   = 32;
	localparam int MUL_DIG_W = 4;
	localparam int MUL_P_W   = MUL_A_W + MUL_G_W;

	// Drive limit: 100 percent in Q16.16
	localparam int          DRV_MAG_W   = 23;
	localparam logic [22:0] DRIVE_LIMIT = 23'd6553600;
	localparam int          DRV_ACC_W   = 42;

	typedef struct packed {
		logic [31:0] prop_gain;
		logic [31:0] integ_gain;
		logic [31:0] deriv_gain;
		logic [31:0] loop_period;
		logic [31:0] inverse_period;
		logic [31:0] rpm_per_count;
		logic [30:0] integral_limit;
		logic [30:0] led_threshold;
	} cfg_t;

	// Saturate sign and magnitude into a signed 32-bit value
	function automatic logic signed [31:0] sat32_mag(input logic neg, input logic [56:0] mag);
		logic signed [31:0] r;
		if (neg) begin
			if (mag > 57'h0_8000_0000) r = 32'sh8000_0000;
			else r = -$signed(mag[31:0]);
		end else begin
			if (mag > 57'h0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
			else r = $signed(mag[31:0]);
		end
		return r;
	endfunction

	// Magnitude of a signed 33-bit value
	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		logic [32:0] r;
		r = v[32] ? 33'(-v) : 33'(v);
		return r;
	endfunction

endpackage

// ----- hw/rtl/pid_motor_speed_loop_top.sv -----
// PID motor speed loop: stream in, stream out, APB configuration.
//
// Input channel (s_*): one transfer per item. s_tuser selects the kind:
// a control tick carrying the raw 32-bit encoder count, or a new setpoint
// in whole rpm (clamped to +-SPEED_LIMIT; clears integral and last error).
// Setpoints and the first tick after reset give no result. Every later tick
// gives one result on the output channel (m_*): PWM duty, bridge direction
// bits, LED level, measured speed and error. A tick runs seven 33x32
// products through one 4-bit-digit serial multiplier and one bit-serial
// division by the 100 percent drive value, one item at a time.
// The result waits in an output register; the next item is accepted while
// it waits, and a tick finishing behind a stalled result holds until the
// receiver takes it. Reset clears the loop state and loads the register
// defaults; the block is ready in the first cycle after reset.
// Depends on pmsl_pkg, pmsl_cfg_regs, pmsl_digit_mul and pmsl_duty_div.
module pid_motor_speed_loop_top #(
	parameter int PWM_TOP     = pmsl_pkg::PWM_TOP_DEF,
	parameter int SPEED_LIMIT = pmsl_pkg::SPEED_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// encoder_count [31:0], new_setpoint [47:32]
	input  logic [pmsl_pkg::IN_W-1:0]     s_tdata,
	// kind [0]
	input  logic                          s_tuser,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pwm_duty [9:0], drive_forward [10], drive_reverse [11], warn_led [12],
	// measured_speed [44:13], speed_error [76:45], zero [79:77]
	output logic [pmsl_pkg::OUT_W-1:0]    m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmsl_pkg::CFG_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import pmsl_pkg::*;

	localparam int DUTY_W = $clog2(PWM_TOP + 1);
	localparam int DUTY_X = DUTY_W + 10;
	localparam int TGT_W  = $clog2(SPEED_LIMIT + 1) + 1;
	localparam int XW     = DRV_MAG_W + DUTY_W;
	localparam logic signed [15:0] LIM16 = 16'(SPEED_LIMIT);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_SPD   = 12'b0000_0000_0010,
		ST_ERR   = 12'b0000_0000_0100,
		ST_INT   = 12'b0000_0000_1000,
		ST_DER   = 12'b0000_0001_0000,
		ST_KP    = 12'b0000_0010_0000,
		ST_KI    = 12'b0000_0100_0000,
		ST_KD    = 12'b0000_1000_0000,
		ST_CLAMP = 12'b0001_0000_0000,
		ST_DUTY  = 12'b0010_0000_0000,
		ST_DIV   = 12'b0100_0000_0000,
		ST_OUT   = 12'b1000_0000_0000
	} st_t;

	cfg_t cfg;

	// Control and loop state
	st_t                      state_q;
	logic                     go_q;
	logic                     primed_q;
	logic [31:0]              prev_count_q;
	logic signed [TGT_W-1:0]  target_q;
	logic signed [31:0]       integral_q;
	logic signed [31:0]       prev_err_q;
	logic                     led_q;
	logic                     m_tvalid_q;

	// Working registers
	logic signed [31:0]           delta_q;
	logic signed [31:0]           speed_q;
	logic signed [31:0]           err_q;
	logic signed [31:0]           deriv_q;
	logic signed [DRV_ACC_W-1:0]  drive_q;
	logic [DRV_MAG_W-1:0]         dmag_q;
	logic                         dneg_q;
	logic [DUTY_W-1:0]            duty_q;
	logic                         mneg_q;
	logic [9:0]                   duty_out_q;
	logic                         fwd_out_q;
	logic                         rev_out_q;
	logic                         led_out_q;
	logic signed [31:0]           speed_out_q;
	logic signed [31:0]           err_out_q;

	// Datapath nets
	logic [31:0]                  count_in;
	logic signed [15:0]           sp_in;
	logic signed [15:0]           sp_clamped;
	logic                         accept;
	logic                         out_free;
	logic [MUL_A_W-1:0]           mul_a;
	logic [MUL_G_W-1:0]           mul_g;
	logic                         mul_neg;
	logic                         mul_done;
	logic [MUL_P_W-1:0]           prod;
	logic                         div_done;
	logic [DUTY_W-1:0]            div_q;
	logic signed [32:0]           diff33;
	logic signed [33:0]           err_wide;
	logic signed [31:0]           err_sat;
	logic signed [DRV_ACC_W-1:0]  shr24_s;
	logic signed [DRV_ACC_W-1:0]  int_sum;
	logic signed [DRV_ACC_W-1:0]  lim_s;
	logic signed [31:0]           integ_new;
	logic [DRV_MAG_W-1:0]         clamp_mag;
	logic [DRV_ACC_W-1:0]         drive_abs;
	logic [32:0]                  err_abs;
	logic                         tgt_zero;
	logic                         led_next;
	logic [DUTY_X-1:0]            duty_ext;

	pmsl_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pmsl_digit_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.a      (mul_a),
		.g      (mul_g),
		.done   (mul_done),
		.prod   (prod)
	);

	pmsl_duty_div #(
		.QW (DUTY_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_q && (state_q == ST_DIV)),
		.dividend (prod[XW-1:0]),
		.done     (div_done),
		.quotient (div_q)
	);

	assign count_in = s_tdata[31:0];
	assign sp_in    = $signed(s_tdata[47:32]);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, err_out_q, speed_out_q, led_out_q, rev_out_q, fwd_out_q,
		duty_out_q};

	// Clamp the requested setpoint
	always_comb begin
		if (sp_in > LIM16) sp_clamped = LIM16;
		else if (sp_in < -LIM16) sp_clamped = -LIM16;
		else sp_clamped = sp_in;
	end

	// Select multiplier operands for the current step
	assign diff33 = 33'(err_q) - 33'(prev_err_q);
	always_comb begin
		mul_a   = '0;
		mul_g   = '0;
		mul_neg = 1'b0;
		unique case (state_q)
			ST_SPD: begin
				mul_a   = mag33(33'(delta_q));
				mul_g   = cfg.rpm_per_count;
				mul_neg = ~delta_q[31];
			end
			ST_INT: begin
				mul_a   = mag33(33'(err_q));
				mul_g   = cfg.loop_period;
				mul_neg = err_q[31];
			end
			ST_DER: begin
				mul_a   = mag33(diff33);
				mul_g   = cfg.inverse_period;
				mul_neg = diff33[32];
			end
			ST_KP: begin
				mul_a   = mag33(33'(err_q));
				mul_g   = cfg.prop_gain;
				mul_neg = err_q[31];
			end
			ST_KI: begin
				mul_a   = mag33(33'(integral_q));
				mul_g   = cfg.integ_gain;
				mul_neg = integral_q[31];
			end
			ST_KD: begin
				mul_a   = mag33(33'(deriv_q));
				mul_g   = cfg.deriv_gain;
				mul_neg = deriv_q[31];
			end
			ST_DUTY: begin
				mul_a   = MUL_A_W'(dmag_q);
				mul_g   = MUL_G_W'(PWM_TOP);
			end
			default: ;
		endcase
	end

	// Error: target in Q16.16 minus speed, saturated
	always_comb begin
		err_wide = (34'(target_q) <<< 16) - 34'(speed_q);
		if (err_wide[33:31] == 3'b000 || err_wide[33:31] == 3'b111) err_sat = err_wide[31:0];
		else if (err_wide[33]) err_sat = 32'sh8000_0000;
		else err_sat = 32'sh7FFF_FFFF;
	end

	// Signed product dropped by 24 bits, integral update and clamp
	always_comb begin
		shr24_s = mneg_q ? -$signed({1'b0, prod[MUL_P_W-1:24]})
			: $signed({1'b0, prod[MUL_P_W-1:24]});
		int_sum = DRV_ACC_W'(integral_q) + shr24_s;
		lim_s   = $signed(DRV_ACC_W'(cfg.integral_limit));
		if (int_sum > lim_s) integ_new = lim_s[31:0];
		else if (int_sum < -lim_s) integ_new = 32'(-lim_s);
		else integ_new = int_sum[31:0];
	end

	// Clamp drive to +-100 percent as magnitude
	always_comb begin
		drive_abs = drive_q[DRV_ACC_W-1] ? DRV_ACC_W'(-drive_q) : DRV_ACC_W'(drive_q);
		if (drive_abs > DRV_ACC_W'(DRIVE_LIMIT)) clamp_mag = DRIVE_LIMIT;
		else clamp_mag = drive_abs[DRV_MAG_W-1:0];
	end

	// LED level and duty formatting
	assign err_abs  = mag33(33'(err_q));
	assign tgt_zero = (target_q == '0);
	always_comb begin
		if (tgt_zero) led_next = 1'b0;
		else if (err_abs[31:0] > {1'b0, cfg.led_threshold}) led_next = ~led_q;
		else led_next = 1'b0;
	end
	assign duty_ext = DUTY_X'(duty_q);

	// Sequence the steps of one tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			go_q         <= 1'b0;
			primed_q     <= 1'b0;
			prev_count_q <= '0;
			target_q     <= '0;
			integral_q   <= '0;
			prev_err_q   <= '0;
			led_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == KIND_SETPOINT) begin
							target_q   <= TGT_W'(sp_clamped);
							integral_q <= '0;
							prev_err_q <= '0;
						end else if (!primed_q) begin
							prev_count_q <= count_in;
							primed_q     <= 1'b1;
						end else begin
							prev_count_q <= count_in;
							state_q      <= ST_SPD;
							go_q         <= 1'b1;
						end
					end
				end
				ST_SPD: if (mul_done) state_q <= ST_ERR;
				ST_ERR: begin
					state_q <= ST_INT;
					go_q    <= 1'b1;
				end
				ST_INT: begin
					if (mul_done) begin
						integral_q <= integ_new;
						state_q    <= ST_DER;
						go_q       <= 1'b1;
					end
				end
				ST_DER: begin
					if (mul_done) begin
						prev_err_q <= err_q;
						state_q    <= ST_KP;
						go_q       <= 1'b1;
					end
				end
				ST_KP: begin
					if (mul_done) begin
						state_q <= ST_KI;
						go_q    <= 1'b1;
					end
				end
				ST_KI: begin
					if (mul_done) begin
						state_q <= ST_KD;
						go_q    <= 1'b1;
					end
				end
				ST_KD: if (mul_done) state_q <= ST_CLAMP;
				ST_CLAMP: begin
					state_q <= ST_DUTY;
					go_q    <= 1'b1;
				end
				ST_DUTY: begin
					if (mul_done) begin
						state_q <= ST_DIV;
						go_q    <= 1'b1;
					end
				end
				ST_DIV: if (div_done) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						led_q      <= led_next;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold working values and the result payload
	always_ff @(posedge clk) begin
		if (go_q) mneg_q <= mul_neg;
		unique case (state_q)
			ST_IDLE:  if (accept) delta_q <= count_in - prev_count_q;
			ST_SPD:   if (mul_done) speed_q <= sat32_mag(mneg_q, prod[MUL_P_W-1:8]);
			ST_ERR:   err_q <= err_sat;
			ST_DER:   if (mul_done) deriv_q <= sat32_mag(mneg_q, 57'(prod[MUL_P_W-1:16]));
			ST_KP:    if (mul_done) drive_q <= shr24_s;
			ST_KI:    if (mul_done) drive_q <= drive_q + shr24_s;
			ST_KD:    if (mul_done) drive_q <= drive_q + shr24_s;
			ST_CLAMP: begin
				dmag_q <= clamp_mag;
				dneg_q <= drive_q[DRV_ACC_W-1];
			end
			ST_DIV:   if (div_done) duty_q <= div_q;
			ST_OUT: begin
				if (out_free) begin
					duty_out_q  <= tgt_zero ? 10'd0 : duty_ext[9:0];
					fwd_out_q   <= !tgt_zero && !dneg_q;
					rev_out_q   <= !tgt_zero && dneg_q;
					led_out_q   <= led_next;
					speed_out_q <= speed_q;
					err_out_q   <= err_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/pmsl_cfg_regs.sv -----
// Configuration register file behind the APB-style port.
// Depends on pmsl_pkg for the register map, reset values and cfg_t.
module pmsl_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmsl_pkg::CFG_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output pmsl_pkg::cfg_t                cfg
);
	import pmsl_pkg::*;

	logic              wr_en;
	logic [CFG_IW-1:0] idx;
	cfg_t              cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[CFG_AW-1:2];
	assign cfg    = cfg_q;

	// Write one register per access transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= RST_PROP_GAIN;
			cfg_q.integ_gain     <= RST_INTEG_GAIN;
			cfg_q.deriv_gain     <= RST_DERIV_GAIN;
			cfg_q.loop_period    <= RST_LOOP_PERIOD;
			cfg_q.inverse_period <= RST_INVERSE_PERIOD;
			cfg_q.rpm_per_count  <= RST_RPM_PER_COUNT;
			cfg_q.integral_limit <= RST_INTEGRAL_LIMIT;
			cfg_q.led_threshold  <= RST_ERROR_THRESH;
		end else if (wr_en) begin
			unique case (idx)
				REG_PROP_GAIN:      cfg_q.prop_gain      <= pwdata;
				REG_INTEG_GAIN:     cfg_q.integ_gain     <= pwdata;
				REG_DERIV_GAIN:     cfg_q.deriv_gain     <= pwdata;
				REG_LOOP_PERIOD:    cfg_q.loop_period    <= pwdata;
				REG_INVERSE_PERIOD: cfg_q.inverse_period <= pwdata;
				REG_RPM_PER_COUNT:  cfg_q.rpm_per_count  <= pwdata;
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= pwdata[30:0];
				REG_ERROR_THRESH:   cfg_q.led_threshold  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			REG_PROP_GAIN:      prdata = cfg_q.prop_gain;
			REG_INTEG_GAIN:     prdata = cfg_q.integ_gain;
			REG_DERIV_GAIN:     prdata = cfg_q.deriv_gain;
			REG_LOOP_PERIOD:    prdata = cfg_q.loop_period;
			REG_INVERSE_PERIOD: prdata = cfg_q.inverse_period;
			REG_RPM_PER_COUNT:  prdata = cfg_q.rpm_per_count;
			REG_INTEGRAL_LIMIT: prdata = {1'b0, cfg_q.integral_limit};
			REG_ERROR_THRESH:   prdata = {1'b0, cfg_q.led_threshold};
			default:            prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/pmsl_digit_mul.sv -----
// Digit-serial unsigned multiplier: one 4-bit digit of the gain per cycle,
// MSB first. Depends on pmsl_pkg for the operand and digit widths.
module pmsl_digit_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pmsl_pkg::MUL_A_W-1:0]   a,
	input  logic [pmsl_pkg::MUL_G_W-1:0]   g,
	output logic                           done,
	output logic [pmsl_pkg::MUL_P_W-1:0]   prod
);
	import pmsl_pkg::*;

	localparam int NDIG  = MUL_G_W / MUL_DIG_W;
	localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NDIG - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [MUL_A_W-1:0]         a_q;
	logic [MUL_G_W-1:0]         g_q;
	logic [MUL_P_W-1:0]         acc_q;
	logic [MUL_A_W+MUL_DIG_W-1:0] pp;

	assign done = done_q;
	assign prod = acc_q;

	// Partial product of the current top digit
	assign pp = {{MUL_DIG_W{1'b0}}, a_q} * {{MUL_A_W{1'b0}}, g_q[MUL_G_W-1 -: MUL_DIG_W]};

	// Count digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift and accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			g_q   <= g;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << MUL_DIG_W) + MUL_P_W'(pp);
			g_q   <= g_q << MUL_DIG_W;
		end
	end

endmodule

// ----- hw/rtl/pmsl_duty_div.sv -----
// Bit-serial restoring divider by the fixed 100 percent drive value,
// one quotient bit per cycle. Depends on pmsl_pkg for DRIVE_LIMIT.
module pmsl_duty_div #(
	parameter int QW = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [pmsl_pkg::DRV_MAG_W+QW-1:0]  dividend,
	output logic                               done,
	output logic [QW-1:0]                      quotient
);
	import pmsl_pkg::*;

	localparam int XW    = DRV_MAG_W + QW;
	localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [XW-1:0]    rem_q;
	logic [XW-1:0]    dsr_q;
	logic [QW-1:0]    quo_q;
	logic             fits;

	assign done     = done_q;
	assign quotient = quo_q;
	assign fits     = rem_q >= dsr_q;

	// Count quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Compare, subtract and shift in one quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= XW'(DRIVE_LIMIT) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) rem_q <= rem_q - dsr_q;
			quo_q <= QW'({quo_q, fits});
			dsr_q <= dsr_q >> 1;
		end
	end

endmodule

// ----- hw/rtl/pmsl_checker.sv -----
// Port-level checks for the PID motor speed loop, bound to the top level.
// Depends on the top level's port list and its PWM_TOP parameter only.
module pmsl_checker #(
	parameter int PWM_TOP = 999
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic [79:0] m_tdata,
	input logic        m_tvalid,
	input logic        m_tready
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Never drive both bridge inputs
	a_dir_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
		else $error("both direction bits set");

	// Duty never exceeds the PWM top value
	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (PWM_TOP > 1023) || (m_tdata[9:0] <= 10'(PWM_TOP)))
		else $error("duty above PWM top");

	// A nonzero duty comes with a direction
	a_duty_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[9:0] != 10'd0) |-> m_tdata[10] || m_tdata[11])
		else $error("duty without direction");

	// A setpoint transfer leaves the input ready in the next cycle
	a_sp_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> s_tready)
		else $error("not ready after setpoint");

endmodule

bind pid_motor_speed_loop_top pmsl_checker #(
	.PWM_TOP (PWM_TOP)
) u_pmsl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

// ----- tb/pid_motor_speed_loop_top_tb.sv -----
// Self-checking testbench for the PID motor speed loop top level.
// Drives ticks and setpoints on the input stream and APB register writes,
// and checks every output transfer against an in-bench loop predictor.
// Depends on pmsl_pkg and pid_motor_speed_loop_top.
module pid_motor_speed_loop_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmsl_pkg::*;

	localparam int     STALL_LIMIT  = 4000;
	localparam int     DRAIN_CYCLES = 120;
	localparam longint S32_MAX      = 2147483647;
	localparam longint S32_MIN      = -S32_MAX - 1;
	localparam longint DRIVE_FULL   = 100 * 65536;

	typedef struct packed {
		logic        kind;
		logic [31:0] count;
		logic [15:0] setpoint;
	} stim_item_t;

	typedef struct packed {
		logic [9:0]  duty;
		logic        fwd;
		logic        rev;
		logic        led;
		logic [31:0] speed;
		logic [31:0] err;
	} loop_result_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic [IN_W-1:0]     s_tdata  = '0;
	logic                s_tuser  = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [CFG_AW-1:0]   paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;

	// Predictor state and register copy
	logic [31:0]  m_cfg [CFG_N];
	logic [31:0]  m_prev_count;
	logic         m_primed;
	longint       m_target;
	longint       m_integral;
	longint       m_prev_err;
	logic         m_led;

	stim_item_t   stim_q [$];
	loop_result_t drive_results_q [$];
	stim_item_t   shown_item;
	logic [31:0]  enc_pos;
	int           idle_pct   = 30;
	int           mismatches = 0;
	int           quiet_cycles = 0;

	pid_motor_speed_loop_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// (a * g) >> sh with truncation toward zero
	function automatic longint scale_trunc(input longint a, input logic [31:0] g, input int sh);
		logic [63:0] mag;
		logic [63:0] prod;
		mag  = (a < 0) ? 64'(-a) : 64'(a);
		prod = (mag * {32'd0, g}) >> sh;
		return (a < 0) ? -$signed(prod) : $signed(prod);
	endfunction

	function automatic longint clip32(input longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	// Advance the predicted loop by one accepted item, queue any result
	task automatic advance_loop(input stim_item_t it);
		longint       sp, delta, speed, err, integ, lim, deriv, drive, mag, aerr;
		logic [31:0]  du;
		loop_result_t r;
		if (it.kind == KIND_SETPOINT) begin
			sp = longint'($signed(it.setpoint));
			if (sp > SPEED_LIMIT_DEF) sp = SPEED_LIMIT_DEF;
			if (sp < -SPEED_LIMIT_DEF) sp = -SPEED_LIMIT_DEF;
			m_target   = sp;
			m_integral = 0;
			m_prev_err = 0;
		end else if (!m_primed) begin
			m_prev_count = it.count;
			m_primed     = 1'b1;
		end else begin
			du           = it.count - m_prev_count;
			m_prev_count = it.count;
			delta        = longint'($signed(du));
			speed = clip32(-scale_trunc(delta, m_cfg[REG_RPM_PER_COUNT], 8));
			err   = clip32(m_target * 65536 - speed);

			// Integrate and clamp (anti-windup)
			integ = m_integral + scale_trunc(err, m_cfg[REG_LOOP_PERIOD], 24);
			lim   = longint'(m_cfg[REG_INTEGRAL_LIMIT]);
			if (integ > lim) integ = lim;
			if (integ < -lim) integ = -lim;
			m_integral = integ;

			deriv = clip32(scale_trunc(err - m_prev_err, m_cfg[REG_INVERSE_PERIOD], 16));
			m_prev_err = err;

			drive = scale_trunc(err, m_cfg[REG_PROP_GAIN], 24)
			      + scale_trunc(integ, m_cfg[REG_INTEG_GAIN], 24)
			      + scale_trunc(deriv, m_cfg[REG_DERIV_GAIN], 24);
			if (drive > DRIVE_FULL) drive = DRIVE_FULL;
			if (drive < -DRIVE_FULL) drive = -DRIVE_FULL;

			// Zero setpoint brakes: no duty, no direction, LED off
			r = '0;
			if (m_target != 0) begin
				mag    = (drive < 0) ? -drive : drive;
				r.duty = 10'((mag * PWM_TOP_DEF) / DRIVE_FULL);
				r.fwd  = (drive >= 0);
				r.rev  = (drive < 0);
			end
			if (m_target == 0) begin
				m_led = 1'b0;
			end else begin
				aerr = (err < 0) ? -err : err;
				if (aerr > longint'(m_cfg[REG_ERROR_THRESH])) m_led = ~m_led;
				else m_led = 1'b0;
			end
			r.led   = m_led;
			r.speed = err[31:0] == err[31:0] ? speed[31:0] : speed[31:0];
			r.err   = err[31:0];
			drive_results_q.push_back(r);
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// Input driver: present the queue head, hold it until the transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				advance_loop(shown_item);
				void'(stim_q.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					shown_item = stim_q[0];
					s_tvalid <= 1'b1;
					s_tdata  <= {shown_item.setpoint, shown_item.count};
					s_tuser  <= shown_item.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		loop_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (drive_results_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %0h", $time, m_tdata);
					mismatches++;
				end else begin
					want = drive_results_q.pop_front();
					check_field("pwm_duty", 32'(want.duty), 32'(m_tdata[9:0]));
					check_field("drive_forward", 32'(want.fwd), 32'(m_tdata[10]));
					check_field("drive_reverse", 32'(want.rev), 32'(m_tdata[11]));
					check_field("warn_led", 32'(want.led), 32'(m_tdata[12]));
					check_field("measured_speed", want.speed, m_tdata[44:13]);
					check_field("speed_error", want.err, m_tdata[76:45]);
				end
			end
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL pid_motor_speed_loop_top");
				$finish;
			end
		end
	end

	task automatic push_tick(input logic [31:0] count);
		stim_item_t it;
		it.kind     = KIND_TICK;
		it.count    = count;
		it.setpoint = 16'($urandom);
		enc_pos     = count;
		stim_q.push_back(it);
	endtask

	task automatic push_setpoint(input logic [15:0] value);
		stim_item_t it;
		it.kind     = KIND_SETPOINT;
		it.count    = $urandom;
		it.setpoint = value;
		stim_q.push_back(it);
	endtask

	// Mostly a smoothly moving encoder, some jumps and setpoint changes
	task automatic push_random(input int n);
		int sel, step;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 75) begin
				step = int'($urandom_range(3000)) - 1500;
				push_tick(enc_pos + 32'(step));
			end else if (sel < 82) begin
				step = int'($urandom_range(200000)) - 100000;
				push_tick(enc_pos + 32'(step));
			end else if (sel < 87) begin
				push_tick($urandom);
			end else if (sel < 93) begin
				push_setpoint(16'(int'($urandom_range(260)) - 130));
			end else if (sel < 95) begin
				push_setpoint(16'd0);
			end else begin
				push_setpoint(16'($urandom));
			end
		end
	endtask

	// Wait for all transfers to complete, then let the block go idle
	task automatic settle();
		while (stim_q.size() != 0 || drive_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_INTEGRAL_LIMIT || idx == REG_ERROR_THRESH)
			m_cfg[idx] = {1'b0, val[30:0]};
		else
			m_cfg[idx] = val;
	endtask

	task automatic write_all(input logic [31:0] vals [CFG_N]);
		for (int i = 0; i < CFG_N; i++) write_reg(CFG_IW'(i), vals[i]);
	endtask

	initial begin
		logic [31:0] vals [CFG_N];
		logic [31:0] defaults [CFG_N];
		defaults[REG_PROP_GAIN]      = RST_PROP_GAIN;
		defaults[REG_INTEG_GAIN]     = RST_INTEG_GAIN;
		defaults[REG_DERIV_GAIN]     = RST_DERIV_GAIN;
		defaults[REG_LOOP_PERIOD]    = RST_LOOP_PERIOD;
		defaults[REG_INVERSE_PERIOD] = RST_INVERSE_PERIOD;
		defaults[REG_RPM_PER_COUNT]  = RST_RPM_PER_COUNT;
		defaults[REG_INTEGRAL_LIMIT] = {1'b0, RST_INTEGRAL_LIMIT};
		defaults[REG_ERROR_THRESH]   = {1'b0, RST_ERROR_THRESH};
		m_cfg        = defaults;
		m_prev_count = '0;
		m_primed     = 1'b0;
		m_target     = 0;
		m_integral   = 0;
		m_prev_err   = 0;
		m_led        = 1'b0;
		enc_pos      = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: priming, count wrap extremes, setpoint clamps, braking
		push_tick(32'h0000_0000);
		push_tick(32'hFFFF_FFFF);
		push_setpoint(16'h7FFF);
		push_tick(32'hFFFF_FFFF);
		push_tick(32'hFFFF_FFFF);
		push_tick(32'h7FFF_FFFE);
		push_tick(32'hFFFF_FFFE);
		push_tick(32'h0000_0100);
		push_setpoint(16'h8000);
		push_tick(32'h0000_0200);
		push_tick(32'h0000_0180);
		push_setpoint(16'd131);
		push_tick(32'h0000_0000);
		push_setpoint(-16'sd131);
		push_tick(32'h0000_01B0);
		push_setpoint(16'd130);
		push_setpoint(-16'sd130);
		push_tick(32'h0000_0300);
		push_setpoint(16'd1);
		push_tick(32'h0000_0303);
		push_setpoint(16'd0);
		push_tick(32'h0000_0500);
		push_tick(32'h0000_0400);
		push_setpoint(16'hFFFF);
		push_tick(32'h0000_0401);
		push_random(300);
		settle();

		// Extremes: everything at full scale
		for (int i = 0; i < CFG_N; i++) vals[i] = 32'hFFFF_FFFF;
		write_all(vals);
		push_random(250);
		settle();

		// Extremes: everything zero
		for (int i = 0; i < CFG_N; i++) vals[i] = 32'h0;
		write_all(vals);
		push_random(200);
		settle();

		// Registers around the defaults, no idling on either side
		for (int i = 0; i < CFG_N; i++) vals[i] = $urandom_range(2 * defaults[i]);
		write_all(vals);
		idle_pct = 0;
		push_random(400);
		settle();
		idle_pct = 30;

		// Full-range random registers
		for (int i = 0; i < CFG_N; i++) vals[i] = $urandom;
		write_all(vals);
		push_random(300);
		settle();

		// Back to the reset values
		write_all(defaults);
		push_random(150);
		settle();

		if (mismatches == 0 && drive_results_q.size() == 0)
			$display("PASS pid_motor_speed_loop_top");
		else
			$display("FAIL pid_motor_speed_loop_top");
		$finish;
	end

endmodule
